[hdl/oaia_pkg.sv]
// Shared types, codes and field widths for the ordered array block.
`timescale 1ns / 1ps

package oaia_pkg;

   localparam int DEFAULT_CAPACITY      = 16;
   localparam int DEFAULT_ELEMENT_WIDTH = 32;

   localparam int OP_W         = 3;
   localparam int POSITION_W   = 5;
   localparam int ELEMENT_IN_W = 32;
   localparam int STATUS_W     = 2;
   localparam int READ_VALUE_W = 32;
   localparam int FOUND_AT_W   = 4;
   localparam int COUNT_W      = 5;

   // stream payload widths, data padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = STATUS_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - READ_VALUE_W - FOUND_AT_W - COUNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND            = 3'd0,
      OP_INSERT_AT         = 3'd1,
      OP_REMOVE_AT         = 3'd2,
      OP_REMOVE_AT_FAST    = 3'd3,
      OP_REMOVE_VALUE      = 3'd4,
      OP_REMOVE_VALUE_FAST = 3'd5,
      OP_READ_AT           = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_FULL    = 2'd1,
      STS_RANGE   = 2'd2,
      STS_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_DOWN,
      S_UP,
      S_FAST_RD,
      S_FAST_WR,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [READ_VALUE_W-1:0]   read_value;
      logic [FOUND_AT_W-1:0]     found_at;
      logic [COUNT_W-1:0]        count_after;
   } result_type;

endpackage

[hdl/oaia_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oaia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/oaia_ctrl.sv]
// Sequencer that walks the entry RAM one address a cycle for shifts and searches.
`timescale 1ns / 1ps

module oaia_ctrl import oaia_pkg::*; #(
   parameter int CAPACITY      = DEFAULT_CAPACITY,
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [OP_W-1:0]             in_op,
   input  logic [POSITION_W-1:0]       in_pos,
   input  logic [ELEMENT_IN_W-1:0]     in_elem,
   output logic                        res_valid,
   input  logic                        res_ack,
   output result_type                  res,
   output logic                        ram_we,
   output logic [$clog2(CAPACITY)-1:0] ram_waddr,
   output logic [ELEMENT_WIDTH-1:0]    ram_wdata,
   output logic                        ram_re,
   output logic [$clog2(CAPACITY)-1:0] ram_raddr,
   input  logic [ELEMENT_WIDTH-1:0]    ram_rdata
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int WW  = (CW > POSITION_W) ? CW : POSITION_W;
   localparam int InW = (ELEMENT_WIDTH < ELEMENT_IN_W) ? ELEMENT_WIDTH : ELEMENT_IN_W;
   localparam logic [CW-1:0] CapC = CW'(CAPACITY);

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [WW-1:0]            pos_ff, pos_in;
   logic [ELEMENT_WIDTH-1:0] elem_ff, elem_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            wa_ff, wa_in;
   logic [AW-1:0]            hole_ff, hole_in;
   status_type               status_ff, status_in;
   logic [ELEMENT_WIDTH-1:0] rv_ff, rv_in;
   logic [AW-1:0]            where_ff, where_in;

   logic [AW-1:0] pos_a;
   logic [AW-1:0] last_a;
   logic [WW-1:0] cnt_w;
   logic [WW-1:0] ptr_w;
   logic          full;
   logic          match;

   assign pos_a  = AW'(pos_ff);
   assign last_a = AW'(cnt_ff - 1'b1);
   assign cnt_w  = WW'(cnt_ff);
   assign ptr_w  = WW'(ptr_ff);
   assign full   = (cnt_ff == CapC);
   // the one comparator: previous read against the searched value
   assign match  = pend_ff && (ram_rdata == elem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      elem_ff   <= elem_in;
      ptr_ff    <= ptr_in;
      wa_ff     <= wa_in;
      hole_ff   <= hole_in;
      status_ff <= status_in;
      rv_ff     <= rv_in;
      where_ff  <= where_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      elem_in   = elem_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      wa_in     = wa_ff;
      hole_in   = hole_ff;
      status_in = status_ff;
      rv_in     = rv_ff;
      where_in  = where_ff;
      ram_we    = 1'b0;
      ram_waddr = wa_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = AW'(ptr_ff);
      in_ready  = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in     = op_type'(in_op);
               pos_in    = WW'(in_pos);
               elem_in   = ELEMENT_WIDTH'(in_elem[InW-1:0]);
               status_in = STS_OK;
               rv_in     = '0;
               where_in  = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff) inside
               OP_APPEND: begin
                  state_in = S_DONE;
                  if (full) begin
                     status_in = STS_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(cnt_ff);
                     ram_wdata = elem_ff;
                     cnt_in    = cnt_ff + 1'b1;
                  end
               end
               OP_INSERT_AT: begin
                  if (full) begin
                     status_in = STS_FULL;
                     state_in  = S_DONE;
                  end else if (pos_ff > cnt_w) begin
                     status_in = STS_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     ptr_in   = cnt_ff;
                     pend_in  = 1'b0;
                     state_in = S_UP;
                  end
               end
               OP_REMOVE_AT, OP_REMOVE_AT_FAST: begin
                  if (pos_ff >= cnt_w) begin
                     status_in = STS_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     hole_in  = pos_a;
                     pend_in  = 1'b0;
                     ptr_in   = CW'(pos_ff) + 1'b1;
                     state_in = (op_ff == OP_REMOVE_AT) ? S_DOWN : S_FAST_RD;
                  end
               end
               OP_REMOVE_VALUE, OP_REMOVE_VALUE_FAST: begin
                  ptr_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_SEARCH;
               end
               OP_READ_AT: begin
                  if (pos_ff >= cnt_w) begin
                     status_in = STS_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = pos_a;
                     state_in  = S_READ;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SEARCH: begin
            if (match) begin
               where_in = wa_ff;
               hole_in  = wa_ff;
               pend_in  = 1'b0;
               ptr_in   = CW'(wa_ff) + 1'b1;
               state_in = (op_ff == OP_REMOVE_VALUE) ? S_DOWN : S_FAST_RD;
            end else if (ptr_ff < cnt_ff) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(ptr_ff);
               pend_in   = 1'b1;
               wa_in     = AW'(ptr_ff);
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  status_in = STS_MISSING;
                  state_in  = S_DONE;
               end
            end
         end
         S_DOWN: begin
            // read i+1 while the entry read last cycle lands at i
            ram_we = pend_ff;
            if (ptr_ff < cnt_ff) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(ptr_ff);
               pend_in   = 1'b1;
               wa_in     = AW'(ptr_ff - 1'b1);
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_UP: begin
            // walk down from the top, moving each entry up by one
            ram_we = pend_ff;
            if (ptr_w > pos_ff) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(ptr_ff - 1'b1);
               pend_in   = 1'b1;
               wa_in     = AW'(ptr_ff);
               ptr_in    = ptr_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = pos_a;
                  ram_wdata = elem_ff;
                  cnt_in    = cnt_ff + 1'b1;
                  state_in  = S_DONE;
               end
            end
         end
         S_FAST_RD: begin
            if (hole_ff == last_a) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = last_a;
               state_in  = S_FAST_WR;
            end
         end
         S_FAST_WR: begin
            ram_we    = 1'b1;
            ram_waddr = hole_ff;
            cnt_in    = cnt_ff - 1'b1;
            state_in  = S_DONE;
         end
         S_READ: begin
            rv_in    = ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.status      = status_ff;
   assign res.read_value  = READ_VALUE_W'(rv_ff);
   assign res.found_at    = FOUND_AT_W'(where_ff);
   assign res.count_after = COUNT_W'(cnt_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CapC)
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr <= AW'(CAPACITY - 1)))
      else $error("RAM write beyond capacity");

   a_down_drops_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOWN && state_in == S_DONE) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("ordered removal did not drop exactly one entry");

   a_done_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> $stable(cnt_ff))
      else $error("count changed while result pending");

endmodule

[hdl/ordered_array_insert_remove.sv]
// Top level: ordered fixed-capacity array with insert, remove, search and read.
`timescale 1ns / 1ps

// Keeps up to CAPACITY elements in order in a single-port-write RAM with a
// count; every request item gives exactly one response item. One item is
// worked on at a time: simple cases (append, errors, read, unused code) go
// from S_EXEC (through S_READ for a read) to S_DONE, while insert, ordered
// removal and value search move or compare one RAM entry per cycle, so an
// item's cost grows with the number of entries compared plus the number moved.
// The RAM's one read and one write per cycle set that rate. A finished
// response sits in an output register, so the next request is taken while it
// waits.

module ordered_array_insert_remove import oaia_pkg::*; #(
   parameter int CAPACITY      = DEFAULT_CAPACITY,
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[4:0], element[36:5], zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // op[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // read_value[31:0], found_at[35:32],
                                             // count_after[40:36], zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser   // status[1:0]
);

   localparam int AW = $clog2(CAPACITY);

   logic                     res_valid;
   logic                     res_ack;
   result_type               res;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [ELEMENT_WIDTH-1:0] ram_wdata;
   logic                     ram_re;
   logic [AW-1:0]            ram_raddr;
   logic [ELEMENT_WIDTH-1:0] ram_rdata;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   oaia_ctrl #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser[OP_W-1:0]),
      .in_pos    (req_tdata[POSITION_W-1:0]),
      .in_elem   (req_tdata[POSITION_W +: ELEMENT_IN_W]),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   oaia_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register: free when empty or being drained this cycle
   assign res_ack = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff.count_after,
                        rsp_res_ff.found_at, rsp_res_ff.read_value};

endmodule

[dv/tb_ordered_array_insert_remove.sv]
// Self-checking testbench for the ordered array block: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_ordered_array_insert_remove import oaia_pkg::*; ();

   localparam int          CAP         = DEFAULT_CAPACITY;
   localparam int          STALL_LIMIT = 1000;
   localparam int          RAND_ITEMS  = 800;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;

   typedef struct {
      logic [2:0]  op;
      logic [4:0]  pos;
      logic [31:0] elem;
      int          reps;
      bit          typed;
      result_type  res;
   } step_row;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // position[4:0], element[36:5], zero pad
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // op[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // read_value[31:0], found_at[35:32],
                                           // count_after[40:36], zero pad
   logic [RSP_USER_W-1:0] rsp_tuser;       // status[1:0]

   // expectation travelling with the item for rows typed in by hand
   bit          row_typed = 1'b0;
   result_type  row_res   = '0;
   bit          calm      = 1'b0;

   logic [31:0] slots [CAP];
   int          fill;
   result_type  pending_outcomes [$];
   int          err_count    = 0;
   int          stall_cycles = 0;
   step_row     plan [$];
   logic [31:0] pool [8];

   ordered_array_insert_remove dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void drop_slot(int idx, bit fast);
      if (fast) begin
         if (idx != fill - 1) slots[idx] = slots[fill - 1];
      end else begin
         for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
      end
      fill--;
   endfunction

   function automatic result_type apply_op(logic [2:0] op, logic [4:0] pos, logic [31:0] elem);
      result_type r;
      int         hit;
      r        = '0;
      r.status = STS_OK;
      hit      = -1;
      case (op)
         OP_APPEND: begin
            if (fill >= CAP) r.status = STS_FULL;
            else begin
               slots[fill] = elem;
               fill++;
            end
         end
         OP_INSERT_AT: begin
            if (fill >= CAP) r.status = STS_FULL;
            else if (pos > fill) r.status = STS_RANGE;
            else begin
               for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
               slots[pos] = elem;
               fill++;
            end
         end
         OP_REMOVE_AT, OP_REMOVE_AT_FAST: begin
            if (pos >= fill) r.status = STS_RANGE;
            else drop_slot(pos, op == OP_REMOVE_AT_FAST);
         end
         OP_REMOVE_VALUE, OP_REMOVE_VALUE_FAST: begin
            for (int i = 0; i < fill && hit < 0; i++)
               if (slots[i] == elem) hit = i;
            if (hit < 0) r.status = STS_MISSING;
            else begin
               r.found_at = hit[3:0];
               drop_slot(hit, op == OP_REMOVE_VALUE_FAST);
            end
         end
         OP_READ_AT: begin
            if (pos >= fill) r.status = STS_RANGE;
            else r.read_value = slots[pos];
         end
         default: ;
      endcase
      r.count_after = fill[4:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- monitors

   always @(posedge clock) begin
      result_type r;
      if (!reset && req_tvalid && req_tready) begin
         r = apply_op(req_tuser, req_tdata[4:0], req_tdata[36:5]);
         pending_outcomes.push_back(row_typed ? row_res : r);
      end
   end

   function automatic void flag(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = status_type'(rsp_tuser);
         got.read_value  = rsp_tdata[31:0];
         got.found_at    = rsp_tdata[35:32];
         got.count_after = rsp_tdata[40:36];
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %p", $time, got);
            err_count++;
         end else begin
            want = pending_outcomes.pop_front();
            flag("status", 32'(want.status), 32'(got.status));
            flag("read_value", want.read_value, got.read_value);
            flag("found_at", 32'(want.found_at), 32'(got.found_at));
            flag("count_after", 32'(want.count_after), 32'(got.count_after));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 17);
   end

   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   function automatic step_row fixed_row(logic [2:0] op, logic [4:0] pos, logic [31:0] elem,
                                         status_type st, logic [31:0] rv, logic [4:0] cnt);
      step_row s;
      s.op  = op;  s.pos = pos;  s.elem = elem;  s.reps = 1;  s.typed = 1'b1;
      s.res = '{status: st, read_value: rv, found_at: 4'd0, count_after: cnt};
      return s;
   endfunction

   function automatic step_row model_row(logic [2:0] op, logic [4:0] pos, logic [31:0] elem,
                                         int reps);
      step_row s;
      s.op  = op;  s.pos = pos;  s.elem = elem;  s.reps = reps;  s.typed = 1'b0;
      s.res = '0;
      return s;
   endfunction

   task automatic issue(logic [2:0] op, logic [4:0] pos, logic [31:0] elem,
                        bit typed, result_type res);
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, elem, pos};
      row_typed  <= typed;
      row_res    <= res;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [2:0]  op;
      logic [4:0]  pos;
      logic [31:0] elem;
      int          pick;
      int          phase_left;
      bit          grow;

      fill = 0;
      foreach (slots[i]) slots[i] = '0;
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) pool[i] = $urandom;

      plan = '{
         // empty array: every index and value lookup fails, then one append and a read back
         fixed_row(OP_READ_AT,           5'd0,  32'h0,         STS_RANGE,   32'h0, 5'd0),
         fixed_row(OP_REMOVE_AT,         5'd0,  32'h0,         STS_RANGE,   32'h0, 5'd0),
         fixed_row(OP_REMOVE_AT_FAST,    5'd0,  32'h0,         STS_RANGE,   32'h0, 5'd0),
         fixed_row(OP_REMOVE_VALUE,      5'd0,  32'h0,         STS_MISSING, 32'h0, 5'd0),
         fixed_row(OP_REMOVE_VALUE_FAST, 5'd0,  32'hFFFF_FFFF, STS_MISSING, 32'h0, 5'd0),
         fixed_row(OP_UNUSED,            5'd31, 32'hFFFF_FFFF, STS_OK,      32'h0, 5'd0),
         fixed_row(OP_INSERT_AT,         5'd1,  32'h1,         STS_RANGE,   32'h0, 5'd0),
         fixed_row(OP_APPEND,            5'd0,  32'hFFFF_FFFF, STS_OK,      32'h0, 5'd1),
         fixed_row(OP_READ_AT,           5'd0,  32'h0, STS_OK, 32'hFFFF_FFFF, 5'd1),
         // fast removal of the only entry
         fixed_row(OP_REMOVE_AT_FAST,    5'd0,  32'h0,         STS_OK,      32'h0, 5'd0),
         fixed_row(OP_INSERT_AT,         5'd0,  32'h0,         STS_OK,      32'h0, 5'd1),
         model_row(OP_APPEND,            5'd0,  32'hA5A5_0000, 14),
         fixed_row(OP_INSERT_AT,         5'd31, 32'h0,         STS_RANGE,   32'h0, 5'd15),
         // insert at the count appends, filling the array
         fixed_row(OP_INSERT_AT,         5'd15, 32'h1234_5678, STS_OK,      32'h0, 5'd16),
         fixed_row(OP_APPEND,            5'd0,  32'h1,         STS_FULL,    32'h0, 5'd16),
         // full test wins over the index test
         fixed_row(OP_INSERT_AT,         5'd31, 32'h1,         STS_FULL,    32'h0, 5'd16),
         fixed_row(OP_READ_AT,           5'd16, 32'h0,         STS_RANGE,   32'h0, 5'd16),
         model_row(OP_READ_AT,           5'd15, 32'h0,         1),
         // match in the top slot, then a hole filled from the end
         model_row(OP_REMOVE_VALUE_FAST, 5'd0,  32'h1234_5678, 1),
         model_row(OP_REMOVE_VALUE_FAST, 5'd0,  32'hA5A5_0003, 1),
         model_row(OP_REMOVE_VALUE,      5'd0,  32'h0,         1),
         model_row(OP_REMOVE_AT,         5'd0,  32'h0,         1),
         model_row(OP_REMOVE_AT_FAST,    5'd12, 32'h0,         1),
         model_row(OP_INSERT_AT,         5'd0,  32'h8000_0000, 1),
         model_row(OP_REMOVE_AT,         5'd31, 32'h0,         1),
         model_row(OP_READ_AT,           5'd1,  32'h0,         1),
         model_row(OP_REMOVE_AT,         5'd0,  32'h0,         13)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         for (int k = 0; k < plan[i].reps; k++)
            issue(plan[i].op, plan[i].pos, plan[i].elem + 32'(k), plan[i].typed, plan[i].res);

      // random part: alternate growing and shrinking spells so both full and
      // empty arrays come round often; values drawn partly from a small pool
      grow       = 1'b1;
      phase_left = $urandom_range(20, 60);
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (phase_left == 0) begin
            grow       = !grow;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         pick = $urandom_range(99);
         if (grow)
            op = pick < 35 ? OP_APPEND : pick < 60 ? OP_INSERT_AT :
                 pick < 67 ? OP_REMOVE_AT : pick < 74 ? OP_REMOVE_AT_FAST :
                 pick < 79 ? OP_REMOVE_VALUE : pick < 84 ? OP_REMOVE_VALUE_FAST :
                 pick < 97 ? OP_READ_AT : OP_UNUSED;
         else
            op = pick < 10 ? OP_APPEND : pick < 20 ? OP_INSERT_AT :
                 pick < 40 ? OP_REMOVE_AT : pick < 60 ? OP_REMOVE_AT_FAST :
                 pick < 75 ? OP_REMOVE_VALUE : pick < 90 ? OP_REMOVE_VALUE_FAST :
                 pick < 98 ? OP_READ_AT : OP_UNUSED;
         pos  = $urandom_range(99) < 80 ? 5'($urandom_range(16)) : 5'($urandom_range(31));
         elem = $urandom_range(99) < 50 ? pool[3'($urandom_range(7))] : 32'($urandom);
         calm <= (n >= 300 && n < 420);
         issue(op, pos, elem, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      // let the last accepted item reach the queue before draining
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (2 * CAP + 10) @(posedge clock);

      if (pending_outcomes.size() != 0) begin
         $display("%0t: %0d items never returned", $time, pending_outcomes.size());
         err_count++;
      end
      if (err_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
